// ----- rtl/perspective_project_to_screen_top_assert.svh -----
// Assertion macros used by the top RTL file of the projection block.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_TOP_ASSERT_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("projection block assertion failed");
`define PPTS_ASSERT_NEXT(lbl, ante, cons) \
  `PPTS_ASSERT(lbl, (ante) |=> (cons))
`else
`define PPTS_ASSERT(lbl, prop)
`define PPTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ppts_pkg.sv -----
package ppts_pkg;

  // Fraction bits of the fixed-point format.
  localparam int FRAC_BITS = 16;

  localparam int ENT_W   = 32;
  localparam int PROD_W  = 2 * ENT_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int CLIP_W  = SUM_W - FRAC_BITS + 1;
  localparam int S_W     = CLIP_W + 1;
  localparam int SIZE_W  = 13;
  localparam int Q_W     = 32;
  localparam int NUM_W   = SIZE_W + S_W + FRAC_BITS - 1;
  localparam int NHI_W   = NUM_W - Q_W;
  localparam int MAT_N   = 8;
  localparam int MAT_IDX_W = 3;
  localparam int REG_W   = 64;
  localparam int ADDR_W  = 6;

  // Visibility threshold: 0.1 rounded to the nearest step.
  localparam longint VIS_THR = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

  typedef logic signed [ENT_W-1:0]  ent_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [CLIP_W-1:0] clip_t;
  typedef logic        [CLIP_W-1:0] den_t;
  typedef logic signed [S_W-1:0]    s_t;
  typedef logic        [S_W-1:0]    mag_t;
  typedef logic        [SIZE_W-1:0] size_t;
  typedef logic        [NUM_W-1:0]  num_t;
  typedef logic        [NHI_W-1:0]  nhi_t;
  typedef logic        [Q_W-1:0]    q_t;
  typedef logic        [REG_W-1:0]  reg_t;

  // One lane of the divider: partial remainder, dividend bits still to
  // shift in, and quotient bits produced so far.
  typedef struct packed {
    den_t rem;
    q_t   lo;
    q_t   quo;
  } div_lane_t;

  // Per-word control that travels alongside the divider.
  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } side_t;

endpackage

// ----- rtl/perspective_project_to_screen_top.sv -----
// Throughput: one word per cycle unless a stalled output holds the pipe;
// the 32-stage divider pipeline (one quotient bit per stage, both screen
// axes side by side) sets the depth.
// Reset: synchronous, active-low rst_n clears all valid bits, the output
// valid bit and the eight matrix registers to zero.
module perspective_project_to_screen_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic [12:0]                   in_window_width,
  input  logic [12:0]                   in_window_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_visible,
  output logic signed [31:0]            out_screen_x,
  output logic signed [31:0]            out_screen_y,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppts_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppts_pkg::REG_W-1:0]    pwdata,
  output logic [ppts_pkg::REG_W-1:0]    prdata,
  output logic                          pready
);

  `include "perspective_project_to_screen_top_assert.svh"

  localparam int QW = ppts_pkg::Q_W;

  // ------------------------------------------------------------------
  // Matrix registers. Each 64-bit register packs two signed entries; row R
  // uses register 2R for columns 0 and 1 and register 2R+1 for column 2 and
  // the translation column.
  // ------------------------------------------------------------------
  ppts_pkg::reg_t mat_r [ppts_pkg::MAT_N];

  assign pready = 1'b1;
  assign prdata = mat_r[paddr[ppts_pkg::ADDR_W-1:ppts_pkg::ADDR_W-ppts_pkg::MAT_IDX_W]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ppts_pkg::MAT_N; i++) begin
        mat_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      mat_r[paddr[ppts_pkg::ADDR_W-1:ppts_pkg::ADDR_W-ppts_pkg::MAT_IDX_W]] <= pwdata;
    end
  end

  function automatic ppts_pkg::ent_t mat_ent(ppts_pkg::reg_t r, int col);
    return (col % 2 == 1) ? ppts_pkg::ent_t'(r[63:32]) : ppts_pkg::ent_t'(r[31:0]);
  endfunction

  // ------------------------------------------------------------------
  // Pipeline flow control. The whole pipe advances together unless a
  // finished word sits in the last divider stage while the output register
  // is still held by a stalled receiver; then every stage holds, bubbles too.
  // ------------------------------------------------------------------
  logic        adv;
  logic        va_r, vb_r, vc_r, vd_r;
  logic [QW:1] vdiv_r;
  logic        out_valid_r;

  assign adv      = !vdiv_r[QW] || !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ------------------------------------------------------------------
  // Stage A: the nine products for rows 0, 1 and 3 (row 2 is never needed).
  // ------------------------------------------------------------------
  ppts_pkg::prod_t prod_r   [3][3];
  ppts_pkg::prod_t prod_nxt [3][3];
  ppts_pkg::size_t wa_r, ha_r;
  ppts_pkg::ent_t  pos [3];

  assign pos[0] = in_pos_x;
  assign pos[1] = in_pos_y;
  assign pos[2] = in_pos_z;

  always_comb begin
    int row;
    for (int ri = 0; ri < 3; ri++) begin
      row = (ri == 2) ? 3 : ri;
      for (int c = 0; c < 3; c++) begin
        prod_nxt[ri][c] = ppts_pkg::prod_t'(pos[c]) *
                          ppts_pkg::prod_t'(mat_ent(mat_r[row*2 + c/2], c));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      wa_r   <= in_window_width;
      ha_r   <= in_window_height;
    end
  end

  // ------------------------------------------------------------------
  // Stage B: exact floor of the product sum, plus the translation entry.
  // ------------------------------------------------------------------
  ppts_pkg::clip_t clip_r   [3];
  ppts_pkg::clip_t clip_nxt [3];
  ppts_pkg::size_t wb_r, hb_r;

  always_comb begin
    ppts_pkg::sum_t acc;
    int row;
    for (int ri = 0; ri < 3; ri++) begin
      row = (ri == 2) ? 3 : ri;
      acc = ppts_pkg::sum_t'(prod_r[ri][0]) + ppts_pkg::sum_t'(prod_r[ri][1]) +
            ppts_pkg::sum_t'(prod_r[ri][2]);
      clip_nxt[ri] = ppts_pkg::clip_t'(acc >>> ppts_pkg::FRAC_BITS) +
                     ppts_pkg::clip_t'(mat_ent(mat_r[row*2 + 1], 3));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r <= clip_nxt;
      wb_r   <= wa_r;
      hb_r   <= ha_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage C: visibility test and the two dividends cw+cx and cw-cy, split
  // into sign and magnitude.
  // ------------------------------------------------------------------
  ppts_pkg::s_t    sx_s, sy_s;
  ppts_pkg::mag_t  magx_r, magy_r;
  logic            negx_r, negy_r, visc_r;
  ppts_pkg::den_t  denc_r;
  ppts_pkg::size_t wc_r, hc_r;

  assign sx_s = ppts_pkg::s_t'(clip_r[2]) + ppts_pkg::s_t'(clip_r[0]);
  assign sy_s = ppts_pkg::s_t'(clip_r[2]) - ppts_pkg::s_t'(clip_r[1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      visc_r <= clip_r[2] >= ppts_pkg::clip_t'(ppts_pkg::VIS_THR);
      negx_r <= sx_s[ppts_pkg::S_W-1];
      negy_r <= sy_s[ppts_pkg::S_W-1];
      magx_r <= sx_s[ppts_pkg::S_W-1] ? ppts_pkg::mag_t'(-sx_s) : ppts_pkg::mag_t'(sx_s);
      magy_r <= sy_s[ppts_pkg::S_W-1] ? ppts_pkg::mag_t'(-sy_s) : ppts_pkg::mag_t'(sy_s);
      denc_r <= ppts_pkg::den_t'(clip_r[2]);
      wc_r   <= wb_r;
      hc_r   <= hb_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage D: scaled numerators size * |s| * 2^(FRAC_BITS-1); the divisor is
  // cw, so the quotient is size * s / (2 * cw) in fixed point.
  // ------------------------------------------------------------------
  ppts_pkg::num_t numx_r, numy_r;
  ppts_pkg::den_t dend_r;
  logic           visd_r, negxd_r, negyd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      numx_r  <= (ppts_pkg::num_t'(wc_r) * ppts_pkg::num_t'(magx_r))
                 << (ppts_pkg::FRAC_BITS - 1);
      numy_r  <= (ppts_pkg::num_t'(hc_r) * ppts_pkg::num_t'(magy_r))
                 << (ppts_pkg::FRAC_BITS - 1);
      dend_r  <= denc_r;
      visd_r  <= visc_r;
      negxd_r <= negx_r;
      negyd_r <= negy_r;
    end
  end

  // ------------------------------------------------------------------
  // Divider entry. When the upper numerator part reaches the divisor the
  // quotient cannot fit in 32 bits and the result saturates; otherwise the
  // upper part is already a valid partial remainder.
  // ------------------------------------------------------------------
  ppts_pkg::nhi_t            nhix, nhiy;
  logic                      ovfx, ovfy;
  ppts_pkg::div_lane_t [1:0] lane_in;
  ppts_pkg::q_t        [1:0] quo;
  ppts_pkg::side_t           side_r   [1:QW];
  ppts_pkg::side_t           side_in;

  assign nhix = numx_r[ppts_pkg::NUM_W-1:QW];
  assign nhiy = numy_r[ppts_pkg::NUM_W-1:QW];
  assign ovfx = ppts_pkg::num_t'(nhix) >= ppts_pkg::num_t'(dend_r);
  assign ovfy = ppts_pkg::num_t'(nhiy) >= ppts_pkg::num_t'(dend_r);

  always_comb begin
    lane_in[0].rem = ppts_pkg::den_t'(nhix);
    lane_in[0].lo  = numx_r[QW-1:0];
    lane_in[0].quo = '0;
    lane_in[1].rem = ppts_pkg::den_t'(nhiy);
    lane_in[1].lo  = numy_r[QW-1:0];
    lane_in[1].quo = '0;
    side_in.vis    = visd_r;
    side_in.neg_x  = negxd_r;
    side_in.neg_y  = negyd_r;
    side_in.ovf_x  = ovfx;
    side_in.ovf_y  = ovfy;
  end

  ppts_div u_div (
    .clk     (clk),
    .en      (adv),
    .lane_in (lane_in),
    .den_in  (dend_r),
    .quo_out (quo)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[1] <= side_in;
      for (int k = 2; k <= QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Valid bits travel with their words through every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      vb_r   <= 1'b0;
      vc_r   <= 1'b0;
      vd_r   <= 1'b0;
      vdiv_r <= '0;
    end else if (adv) begin
      va_r   <= in_valid;
      vb_r   <= va_r;
      vc_r   <= vb_r;
      vd_r   <= vc_r;
      vdiv_r <= {vdiv_r[QW-1:1], vd_r};
    end
  end

  // ------------------------------------------------------------------
  // Output: apply sign and saturate. Positive results clamp to 2^31-1,
  // negative ones to -2^31; a hidden point reports zero coordinates.
  // ------------------------------------------------------------------
  ppts_pkg::side_t sd;
  logic [31:0]     satx, saty;
  logic            out_visible_r;
  logic [31:0]     out_screen_x_r, out_screen_y_r;

  assign sd = side_r[QW];

  always_comb begin
    if (sd.neg_x) begin
      satx = (sd.ovf_x || quo[0][QW-1]) ? 32'h8000_0000 : -quo[0];
    end else begin
      satx = (sd.ovf_x || quo[0][QW-1]) ? 32'h7FFF_FFFF : quo[0];
    end
    if (sd.neg_y) begin
      saty = (sd.ovf_y || quo[1][QW-1]) ? 32'h8000_0000 : -quo[1];
    end else begin
      saty = (sd.ovf_y || quo[1][QW-1]) ? 32'h7FFF_FFFF : quo[1];
    end
    if (!sd.vis) begin
      satx = '0;
      saty = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= vdiv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid_r || !out_stall) && vdiv_r[QW]) begin
      out_visible_r  <= sd.vis;
      out_screen_x_r <= satx;
      out_screen_y_r <= saty;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_visible_r;
  assign out_screen_x = out_screen_x_r;
  assign out_screen_y = out_screen_y_r;

  // A hidden point never carries coordinates.
  `PPTS_ASSERT(a_hidden_zero, out_valid_r && !out_visible_r |-> out_screen_x_r == '0 && out_screen_y_r == '0)
  // Input is held off only when a finished word is blocked behind the output.
  `PPTS_ASSERT(a_stall_cause, in_stall |-> out_valid_r && out_stall && vdiv_r[QW])
  // An accepted word occupies the first stage on the next cycle.
  `PPTS_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, va_r)
  // A word leaving the divider lands in the output register.
  `PPTS_ASSERT_NEXT(a_last_lands, vdiv_r[QW] && adv, out_valid_r)

endmodule

// ----- rtl/ppts_div.sv -----
module ppts_div (
  input  logic                      clk,
  input  logic                      en,
  input  ppts_pkg::div_lane_t [1:0] lane_in,
  input  ppts_pkg::den_t            den_in,
  output ppts_pkg::q_t        [1:0] quo_out
);

  // One restoring step per stage, both lanes share the divisor.
  function automatic ppts_pkg::div_lane_t div_step(ppts_pkg::div_lane_t l,
                                                   ppts_pkg::den_t d);
    logic [ppts_pkg::CLIP_W:0] rs;
    logic                      ge;
    ppts_pkg::div_lane_t       o;
    rs    = {l.rem, l.lo[ppts_pkg::Q_W-1]};
    ge    = rs >= {1'b0, d};
    o.rem = ge ? ppts_pkg::den_t'(rs - {1'b0, d}) : ppts_pkg::den_t'(rs);
    o.lo  = {l.lo[ppts_pkg::Q_W-2:0], 1'b0};
    o.quo = {l.quo[ppts_pkg::Q_W-2:0], ge};
    return o;
  endfunction

  ppts_pkg::div_lane_t [1:0] lane_r   [1:ppts_pkg::Q_W];
  ppts_pkg::div_lane_t [1:0] lane_nxt [1:ppts_pkg::Q_W];
  ppts_pkg::den_t            den_r    [1:ppts_pkg::Q_W];
  ppts_pkg::den_t            den_nxt  [1:ppts_pkg::Q_W];

  always_comb begin
    den_nxt[1]     = den_in;
    lane_nxt[1][0] = div_step(lane_in[0], den_in);
    lane_nxt[1][1] = div_step(lane_in[1], den_in);
    for (int k = 2; k <= ppts_pkg::Q_W; k++) begin
      den_nxt[k]     = den_r[k-1];
      lane_nxt[k][0] = div_step(lane_r[k-1][0], den_r[k-1]);
      lane_nxt[k][1] = div_step(lane_r[k-1][1], den_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= ppts_pkg::Q_W; k++) begin
        lane_r[k] <= lane_nxt[k];
        den_r[k]  <= den_nxt[k];
      end
    end
  end

  assign quo_out[0] = lane_r[ppts_pkg::Q_W][0].quo;
  assign quo_out[1] = lane_r[ppts_pkg::Q_W][1].quo;

endmodule
